@@ rtl/kms_pkg.sv @@
// Shared types, codes and size defaults for the k-way sorted merge block.
package kms_pkg;

   // Default store geometry.
   localparam int MAX_ROWS_DEF = 8;
   localparam int MAX_COLS_DEF = 64;

   // Field widths of the request, response and register port.
   localparam int ROW_SEL_W = 3;
   localparam int COL_SEL_W = 6;
   localparam int VALUE_W   = 32;
   localparam int ROWS_CSR_W = 4;
   localparam int COLS_CSR_W = 7;
   localparam int CSR_DATA_W = 7;
   localparam int CSR_IDX_W  = 1;

   // Register reset values.
   localparam logic [ROWS_CSR_W-1:0] ROWS_RESET = 4'd8;
   localparam logic [COLS_CSR_W-1:0] COLS_RESET = 7'd64;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS_IN_USE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COLS_IN_USE = 1'b1;

   // Request kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_RESULT
   } state_type;

endpackage

@@ rtl/kms_store.sv @@
// Single-port-write, single-port-read element memory with registered read data.
module kms_store #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/k_way_sorted_merge.sv @@
// Top level of the k-way sorted merge: request decode, head scan and result register.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  kind, row_sel, col_sel, element_value
//   rsp_      out        rsp_valid/rsp_ready  out_value, out_valid, out_last
//   csr_      in         csr_wr_en            csr_index, csr_wdata
//
// A load writes the element memory in its transfer cycle; the commit state then
// moves the result into the output register. A pop passes the transfer cycle, a
// scan that reads the head of each active, unexhausted row through the single
// read port of the element memory, a drain state that compares the last head,
// and a commit state that advances the pointer and loads the output register.
// Reset clears the row pointers, the state machine and the output valid flag;
// the element memory has no reset. A held response only stalls the commit cycle.
module k_way_sorted_merge
   import kms_pkg::*;
#(
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int MAX_COLS = MAX_COLS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   // Request channel.
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [ROW_SEL_W-1:0]         req_row_sel,
   input  logic [COL_SEL_W-1:0]         req_col_sel,
   input  logic signed [VALUE_W-1:0]    req_element_value,
   // Response channel.
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [VALUE_W-1:0]    rsp_out_value,
   output logic                         rsp_out_valid,
   output logic                         rsp_out_last,
   // Register write port.
   input  logic                         csr_wr_en,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_wdata
);

   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int PTR_W  = $clog2(MAX_COLS + 1);

   // Configuration registers.
   logic [ROWS_CSR_W-1:0] rows_in_use_ff;
   logic [COLS_CSR_W-1:0] cols_in_use_ff;

   // Control state.
   state_type state_ff, state_in;
   logic [PTR_W-1:0] ptr_ff [MAX_ROWS];
   logic [ROW_W-1:0] scan_idx_ff;

   // Head scan stage: the row whose head is in flight through the memory.
   logic             s1_valid_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic [PTR_W-1:0] s1_ptr_ff;

   // Running minimum over the heads seen so far.
   logic                     found_ff;
   logic [1:0]               avail_ff;
   logic signed [VALUE_W-1:0] best_val_ff;
   logic [ROW_W-1:0]         best_row_ff;
   logic [PTR_W-1:0]         best_ptr_ff;

   // Output register.
   logic                      rsp_valid_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_out_valid_ff;
   logic                      rsp_last_ff;

   logic [RCNT_W-1:0] rows_eff;
   logic [PTR_W-1:0]  cols_eff;
   logic              req_xfer;
   logic              slot_free;
   logic              commit;
   logic              scan_live;
   logic              scan_last;
   logic              load_in_store;
   logic              any_left;
   logic [PTR_W-1:0]  scan_ptr;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [VALUE_W-1:0] rd_data;
   logic signed [VALUE_W-1:0] head_val;

   // Out-of-range register values are clamped where they are used.
   always_comb begin
      if (rows_in_use_ff == '0) begin
         rows_eff = RCNT_W'(1);
      end else if (int'(rows_in_use_ff) > MAX_ROWS) begin
         rows_eff = RCNT_W'(MAX_ROWS);
      end else begin
         rows_eff = RCNT_W'(rows_in_use_ff);
      end
      if (cols_in_use_ff == '0) begin
         cols_eff = PTR_W'(1);
      end else if (int'(cols_in_use_ff) > MAX_COLS) begin
         cols_eff = PTR_W'(MAX_COLS);
      end else begin
         cols_eff = PTR_W'(cols_in_use_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_in_use_ff <= ROWS_RESET;
         cols_in_use_ff <= COLS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ROWS_IN_USE: rows_in_use_ff <= csr_wdata[ROWS_CSR_W-1:0];
            CSR_COLS_IN_USE: cols_in_use_ff <= csr_wdata[COLS_CSR_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign commit    = (state_ff == ST_RESULT) && slot_free;

   // A load writes the memory in its transfer cycle; loads outside the store
   // still rewind the merge but leave the memory untouched.
   assign load_in_store = (int'(req_row_sel) < MAX_ROWS) && (int'(req_col_sel) < MAX_COLS);
   assign wr_addr = ADDR_W'(int'(req_row_sel) * MAX_COLS + int'(req_col_sel));

   // The scan reads one row head per cycle; exhausted rows issue no read.
   assign scan_ptr  = ptr_ff[scan_idx_ff];
   assign scan_live = (state_ff == ST_SCAN) && (scan_ptr < cols_eff);
   assign scan_last = (int'(scan_idx_ff) == int'(rows_eff) - 1);
   assign rd_addr   = ADDR_W'(int'(scan_idx_ff) * MAX_COLS + int'(scan_ptr));

   kms_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W),
      .DATA_W (VALUE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_xfer && (req_kind == KIND_LOAD) && load_in_store),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_en   (scan_live),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign head_val = $signed(rd_data);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == KIND_POP) ? ST_SCAN : ST_RESULT;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Scan control and the running minimum. A head replaces the best one only
   // when strictly smaller, so ties keep the lowest row.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff <= '0;
         s1_valid_ff <= 1'b0;
         found_ff    <= 1'b0;
         avail_ff    <= '0;
      end else begin
         s1_valid_ff <= scan_live;
         if (req_xfer) begin
            scan_idx_ff <= '0;
            found_ff    <= 1'b0;
            avail_ff    <= '0;
         end else begin
            if (state_ff == ST_SCAN && !scan_last) begin
               scan_idx_ff <= scan_idx_ff + 1'b1;
            end
            if (s1_valid_ff) begin
               found_ff <= 1'b1;
               if (avail_ff != 2'd2) begin
                  avail_ff <= avail_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_row_ff <= scan_idx_ff;
      s1_ptr_ff <= scan_ptr;
      if (s1_valid_ff && (!found_ff || (head_val < best_val_ff))) begin
         best_val_ff <= head_val;
         best_row_ff <= s1_row_ff;
         best_ptr_ff <= s1_ptr_ff;
      end
   end

   // Row pointers: every load rewinds them, a delivered pop advances one.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            ptr_ff[r] <= '0;
         end
      end else if (req_xfer && (req_kind == KIND_LOAD)) begin
         for (int r = 0; r < MAX_ROWS; r++) begin
            ptr_ff[r] <= '0;
         end
      end else if (commit && found_ff) begin
         ptr_ff[best_row_ff] <= best_ptr_ff + 1'b1;
      end
   end

   // Something is left after this pop if another row still had a head, or if
   // the chosen row has more columns after the one just taken.
   assign any_left = (avail_ff == 2'd2) ||
                     ({1'b0, best_ptr_ff} + 1'b1 < {1'b0, cols_eff});

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_value_ff     <= found_ff ? best_val_ff : '0;
         rsp_out_valid_ff <= found_ff;
         rsp_last_ff      <= found_ff && !any_left;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_valid = rsp_out_valid_ff;
   assign rsp_out_last  = rsp_last_ff;

`ifndef ASSERT_OFF
   // A final-element flag only ever comes with a delivered element.
   a_last_has_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_last_ff |-> rsp_out_valid_ff)
      else $error("last flag without a delivered element");

   // A load goes straight to the commit state.
   a_load_to_result: assert property (@(posedge clock) disable iff (reset)
      req_xfer && (req_kind == KIND_LOAD) |=> state_ff == ST_RESULT)
      else $error("load did not reach the commit state");

   // Head reads are only in flight while the scan runs.
   a_s1_in_scan: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_DRAIN))
      else $error("head read in flight outside the scan");

   // A pointer is only advanced from a position below the column count.
   a_ptr_bound: assert property (@(posedge clock) disable iff (reset)
      commit && found_ff |-> best_ptr_ff < cols_eff)
      else $error("pointer advanced past the column count");

   // The output register is never overwritten while it holds an untaken result.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(rsp_value_ff))
      else $error("pending result overwritten");
`endif

endmodule
